### rtl/core/tfs_pkg.sv
// ============================================================================
// tfs_pkg
// Shared widths, codes and controller/datapath handshake types of the
// TCP flow scheduler.
// ============================================================================
package tfs_pkg;

  // Field and register widths
  localparam int FLOWS_W     = 7;
  localparam int SIZE_W      = 16;
  localparam int LIMIT_W     = 32;
  localparam int SENT_W      = 32;
  localparam int RND_W       = 29;
  localparam int PORT_W      = 16;
  localparam int KIND_W      = 2;
  localparam int FLOW_IDX_W  = 6;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  // Default flow table depth
  localparam int MAX_FLOWS_DEFAULT = 64;

  // Flow table entry: progress, source port, destination port
  localparam int ENTRY_W = SIZE_W + 2 * PORT_W;

  // Modulo unit: dividend padded to DIV_W, DIV_STEPS bits per cycle
  localparam int DIV_W      = 32;
  localparam int DIV_STEPS  = 8;
  localparam int DIV_CYCLES = DIV_W / DIV_STEPS;
  localparam int DIV_CNT_W  = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

  // Smallest usable flow size and saturation value of the sent counter
  localparam logic [SIZE_W-1:0] MIN_SIZE = SIZE_W'(3);
  localparam logic [SENT_W-1:0] SENT_MAX = '1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FLOWS_IN_USE    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PACKETS_PER_FLOW = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_ENABLED   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_PACKET_LIMIT    = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_GENERATOR_ACTIVE = CFG_IDX_W'(4);

  // Item commands
  localparam logic CMD_PULL  = 1'b0;
  localparam logic CMD_RESET = 1'b1;

  // Packet kinds
  localparam logic [KIND_W-1:0] KIND_SYN  = KIND_W'(0);
  localparam logic [KIND_W-1:0] KIND_DATA = KIND_W'(1);
  localparam logic [KIND_W-1:0] KIND_FIN  = KIND_W'(2);

  // Result-producing operations issued by the controller
  typedef enum logic [2:0] {
    OP_NOP,
    OP_RESET_ITEM,
    OP_SKIP,
    OP_PULL,
    OP_CLOSE,
    OP_ALL_DONE
  } op_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic clear_we;
    logic addr_inc;
    logic addr_rem;
    logic div_step;
    op_t  op;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic command;
    logic active;
    logic at_limit;
    logic fins_done;
    logic scan_hit;
    logic addr_last;
    logic clear_last;
    logic out_free;
  } ctrl_sts_t;

endpackage

### rtl/core/tfs_item_if.sv
// ============================================================================
// tfs_item_if
// Input channel of the flow scheduler: one pull or reset item per handshake.
// ============================================================================
interface tfs_item_if;
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic [tfs_pkg::RND_W-1:0]     random_word;
  logic [tfs_pkg::PORT_W-1:0]    fresh_src_port;
  logic [tfs_pkg::PORT_W-1:0]    fresh_dst_port;

  modport source (
    output valid, command, random_word, fresh_src_port, fresh_dst_port,
    input  ready
  );

  modport sink (
    input  valid, command, random_word, fresh_src_port, fresh_dst_port,
    output ready
  );
endinterface

### rtl/core/tfs_result_if.sv
// ============================================================================
// tfs_result_if
// Result channel of the flow scheduler: one result item per input item.
// ============================================================================
interface tfs_result_if;
  logic                             valid;
  logic                             ready;
  logic                             emitted;
  logic [tfs_pkg::KIND_W-1:0]       packet_kind;
  logic [tfs_pkg::FLOW_IDX_W-1:0]   flow_index;
  logic [tfs_pkg::PORT_W-1:0]       src_port;
  logic [tfs_pkg::PORT_W-1:0]       dst_port;
  logic                             all_finished;
  logic [tfs_pkg::SENT_W-1:0]       sent_total;

  modport source (
    output valid, emitted, packet_kind, flow_index, src_port, dst_port,
           all_finished, sent_total,
    input  ready
  );

  modport sink (
    input  valid, emitted, packet_kind, flow_index, src_port, dst_port,
           all_finished, sent_total,
    output ready
  );
endinterface

### rtl/core/tcp_flow_traffic_scheduler.sv
// ============================================================================
// tcp_flow_traffic_scheduler
// Flow scheduler of a TCP traffic generator: picks a flow per pull item,
// steps its packet counter and reports SYN, DATA or FIN with its ports.
// ============================================================================
// Usage:
//   item   : pull (command 0) or reset (command 1) items, valid/ready.
//   result : exactly one result item per input item, valid/ready.
//   cfg_*  : register writes, taken on any cycle with cfg_write high; write
//            only while no item is in flight.
// Steps from acceptance to the result being valid:
//   reset item or idle pull : issued directly from the finish step.
//   normal pull             : 4 modulo iterations of 8 bits each, table
//                             read, table update.
//   closing pull            : a scan of the flows, one flow table entry
//                             per cycle.
//   The next item is accepted in the cycle after the result is registered.
// After reset the flow table is swept to zero, one entry per cycle, over
// all MAX_FLOWS entries; items wait, configuration writes are taken meanwhile.
// A stalled result is held in its output register; one further item may be
// accepted and worked on, and waits at its last step until the output frees.
// ============================================================================
module tcp_flow_traffic_scheduler #(
  parameter int MAX_FLOWS = tfs_pkg::MAX_FLOWS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  tfs_item_if.sink                        item,
  tfs_result_if.source                    result,
  input  logic                            cfg_write,
  input  logic [tfs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tfs_pkg::CFG_DATA_W-1:0]  cfg_data
);

  tfs_pkg::ctrl_cmd_t cmd;
  tfs_pkg::ctrl_sts_t sts;

  // Sequencer
  tfs_controller u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // Datapath and flow table
  tfs_datapath #(
    .MAX_FLOWS (MAX_FLOWS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .item_command     (item.command),
    .item_random_word (item.random_word),
    .item_src_port    (item.fresh_src_port),
    .item_dst_port    (item.fresh_dst_port),
    .cmd              (cmd),
    .sts              (sts),
    .res_valid        (result.valid),
    .res_ready        (result.ready),
    .res_emitted      (result.emitted),
    .res_kind         (result.packet_kind),
    .res_flow         (result.flow_index),
    .res_src          (result.src_port),
    .res_dst          (result.dst_port),
    .res_fin          (result.all_finished),
    .res_sent         (result.sent_total)
  );

endmodule

### rtl/core/tfs_ram.sv
// ============================================================================
// tfs_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module tfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/tfs_datapath.sv
// ============================================================================
// tfs_datapath
// Configuration registers, modulo unit, flow table, counters and the
// registered result stage of the flow scheduler.
// ============================================================================
module tfs_datapath #(
  parameter int MAX_FLOWS = tfs_pkg::MAX_FLOWS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_write,
  input  logic [tfs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tfs_pkg::CFG_DATA_W-1:0]      cfg_data,
  // item payload
  input  logic                                item_command,
  input  logic [tfs_pkg::RND_W-1:0]           item_random_word,
  input  logic [tfs_pkg::PORT_W-1:0]          item_src_port,
  input  logic [tfs_pkg::PORT_W-1:0]          item_dst_port,
  // controller link
  input  tfs_pkg::ctrl_cmd_t                  cmd,
  output tfs_pkg::ctrl_sts_t                  sts,
  // result channel
  output logic                                res_valid,
  input  logic                                res_ready,
  output logic                                res_emitted,
  output logic [tfs_pkg::KIND_W-1:0]          res_kind,
  output logic [tfs_pkg::FLOW_IDX_W-1:0]      res_flow,
  output logic [tfs_pkg::PORT_W-1:0]          res_src,
  output logic [tfs_pkg::PORT_W-1:0]          res_dst,
  output logic                                res_fin,
  output logic [tfs_pkg::SENT_W-1:0]          res_sent
);

  localparam int AW = (MAX_FLOWS > 1) ? $clog2(MAX_FLOWS) : 1;
  localparam int NW = $clog2(MAX_FLOWS + 1);
  localparam int CW = (NW > tfs_pkg::FLOWS_W) ? NW : tfs_pkg::FLOWS_W;

  // Configuration registers
  logic [tfs_pkg::FLOWS_W-1:0]  flows_cfg;
  logic [tfs_pkg::SIZE_W-1:0]   size_cfg;
  logic                         limit_en;
  logic [tfs_pkg::LIMIT_W-1:0]  limit_val;
  logic                         active;

  // Scheduler state
  logic [tfs_pkg::SENT_W-1:0]   sent;
  logic                         fins_done;

  // Latched item and modulo unit
  logic [tfs_pkg::PORT_W-1:0]   src_q;
  logic [tfs_pkg::PORT_W-1:0]   dst_q;
  logic [tfs_pkg::DIV_W-1:0]    div_q;
  logic [NW-1:0]                rem;
  logic [tfs_pkg::DIV_W-1:0]    div_q_next;
  logic [NW-1:0]                rem_next;

  // Flow table address
  logic [AW-1:0]                addr;
  logic [AW-1:0]                addr_next;

  // Flow table ports
  logic                         ram_we;
  logic [tfs_pkg::ENTRY_W-1:0]  ram_wdata;
  logic [tfs_pkg::ENTRY_W-1:0]  ram_rdata;

  // Derived values
  logic [CW-1:0]                flows_ext;
  logic [NW-1:0]                n_eff;
  logic [tfs_pkg::SIZE_W-1:0]   size_eff;
  logic                         at_limit;
  logic [tfs_pkg::SIZE_W-1:0]   e_prog;
  logic [tfs_pkg::PORT_W-1:0]   e_src;
  logic [tfs_pkg::PORT_W-1:0]   e_dst;
  logic                         restart;
  logic [tfs_pkg::SIZE_W-1:0]   new_prog;
  logic [tfs_pkg::PORT_W-1:0]   new_src;
  logic [tfs_pkg::PORT_W-1:0]   new_dst;
  logic [tfs_pkg::KIND_W-1:0]   pull_kind;
  logic [tfs_pkg::SENT_W-1:0]   sent_inc;
  logic                         out_free;

  // Clamp flow count and flow size into their usable ranges
  assign flows_ext = CW'(flows_cfg);
  always_comb begin
    priority if (flows_ext == '0) begin
      n_eff = NW'(1);
    end else if (flows_ext > CW'(MAX_FLOWS)) begin
      n_eff = NW'(MAX_FLOWS);
    end else begin
      n_eff = NW'(flows_ext);
    end
  end

  assign size_eff = (size_cfg < tfs_pkg::MIN_SIZE) ? tfs_pkg::MIN_SIZE : size_cfg;
  assign at_limit = limit_en && (sent >= limit_val);
  assign sent_inc = (sent == tfs_pkg::SENT_MAX) ? sent : sent + tfs_pkg::SENT_W'(1);
  assign out_free = !res_valid || res_ready;

  // Modulo unit: several restoring steps per cycle, remainder stays below n
  always_comb begin : div_comb
    logic [NW:0]               r;
    logic [tfs_pkg::DIV_W-1:0] d;
    r = {1'b0, rem};
    d = div_q;
    for (int k = 0; k < tfs_pkg::DIV_STEPS; k++) begin
      r = {r[NW-1:0], d[tfs_pkg::DIV_W-1]};
      d = {d[tfs_pkg::DIV_W-2:0], 1'b0};
      if (r >= {1'b0, n_eff}) begin
        r = r - {1'b0, n_eff};
      end
    end
    rem_next   = r[NW-1:0];
    div_q_next = d;
  end

  // Select the next table address; it drives the read port, whose registered data follows in the next cycle
  always_comb begin
    addr_next = addr;
    priority if (cmd.load) begin
      addr_next = '0;
    end else if (cmd.addr_rem) begin
      addr_next = AW'(rem);
    end else if (cmd.addr_inc) begin
      addr_next = addr + AW'(1);
    end
  end

  // Split the table entry and work out the pull update
  assign e_prog = ram_rdata[tfs_pkg::ENTRY_W-1 -: tfs_pkg::SIZE_W];
  assign e_src  = ram_rdata[2*tfs_pkg::PORT_W-1 -: tfs_pkg::PORT_W];
  assign e_dst  = ram_rdata[tfs_pkg::PORT_W-1:0];

  assign restart  = (e_prog == '0) || (e_prog >= size_eff);
  assign new_prog = (restart ? '0 : e_prog) + tfs_pkg::SIZE_W'(1);
  assign new_src  = restart ? src_q : e_src;
  assign new_dst  = restart ? dst_q : e_dst;

  always_comb begin
    priority if (new_prog == tfs_pkg::SIZE_W'(1)) begin
      pull_kind = tfs_pkg::KIND_SYN;
    end else if (new_prog == size_eff) begin
      pull_kind = tfs_pkg::KIND_FIN;
    end else begin
      pull_kind = tfs_pkg::KIND_DATA;
    end
  end

  // Table write: clearing sweep, pull update or forced close
  always_comb begin
    ram_we    = 1'b0;
    ram_wdata = '0;
    if (cmd.clear_we) begin
      ram_we = 1'b1;
    end else if (cmd.op == tfs_pkg::OP_PULL) begin
      ram_we    = 1'b1;
      ram_wdata = {new_prog, new_src, new_dst};
    end else if (cmd.op == tfs_pkg::OP_CLOSE) begin
      ram_we    = 1'b1;
      ram_wdata = {size_eff, e_src, e_dst};
    end
  end

  tfs_ram #(
    .WIDTH (tfs_pkg::ENTRY_W),
    .DEPTH (MAX_FLOWS)
  ) u_flow_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata (ram_wdata),
    .raddr (addr_next),
    .rdata (ram_rdata)
  );

  // Status back to the controller
  assign sts.command    = item_command;
  assign sts.active     = active;
  assign sts.at_limit   = at_limit;
  assign sts.fins_done  = fins_done;
  assign sts.scan_hit   = (e_prog < size_eff);
  assign sts.addr_last  = ((NW'(addr) + NW'(1)) == n_eff);
  assign sts.clear_last = (addr == AW'(MAX_FLOWS - 1));
  assign sts.out_free   = out_free;

  // Latch the item and step the modulo unit
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      src_q <= item_src_port;
      dst_q <= item_dst_port;
      div_q <= tfs_pkg::DIV_W'(item_random_word);
      rem   <= '0;
    end else if (cmd.div_step) begin
      div_q <= div_q_next;
      rem   <= rem_next;
    end
  end

  // Address register
  always_ff @(posedge clk) begin
    if (rst) begin
      addr <= '0;
    end else begin
      addr <= addr_next;
    end
  end

  // Configuration, counters and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      flows_cfg <= tfs_pkg::FLOWS_W'(1);
      size_cfg  <= tfs_pkg::MIN_SIZE;
      limit_en  <= 1'b0;
      limit_val <= '0;
      active    <= 1'b1;
      sent      <= '0;
      fins_done <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          tfs_pkg::REG_FLOWS_IN_USE:     flows_cfg <= cfg_data[tfs_pkg::FLOWS_W-1:0];
          tfs_pkg::REG_PACKETS_PER_FLOW: size_cfg  <= cfg_data[tfs_pkg::SIZE_W-1:0];
          tfs_pkg::REG_LIMIT_ENABLED:    limit_en  <= cfg_data[0];
          tfs_pkg::REG_PACKET_LIMIT:     limit_val <= cfg_data[tfs_pkg::LIMIT_W-1:0];
          tfs_pkg::REG_GENERATOR_ACTIVE: begin
            active <= cfg_data[0];
            if (cfg_data[0]) begin
              sent      <= '0;
              fins_done <= 1'b0;
            end
          end
          default: ;
        endcase
      end

      unique case (cmd.op)
        tfs_pkg::OP_RESET_ITEM: begin
          sent      <= '0;
          fins_done <= 1'b0;
        end
        tfs_pkg::OP_PULL, tfs_pkg::OP_CLOSE: sent <= sent_inc;
        tfs_pkg::OP_ALL_DONE: fins_done <= 1'b1;
        default: ;
      endcase

      if (cmd.op != tfs_pkg::OP_NOP) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      tfs_pkg::OP_PULL: begin
        res_emitted <= 1'b1;
        res_kind    <= pull_kind;
        res_flow    <= tfs_pkg::FLOW_IDX_W'(addr);
        res_src     <= new_src;
        res_dst     <= new_dst;
        res_fin     <= fins_done;
        res_sent    <= sent_inc;
      end
      tfs_pkg::OP_CLOSE: begin
        res_emitted <= 1'b1;
        res_kind    <= tfs_pkg::KIND_FIN;
        res_flow    <= tfs_pkg::FLOW_IDX_W'(addr);
        res_src     <= e_src;
        res_dst     <= e_dst;
        res_fin     <= fins_done;
        res_sent    <= sent_inc;
      end
      tfs_pkg::OP_RESET_ITEM, tfs_pkg::OP_SKIP, tfs_pkg::OP_ALL_DONE: begin
        res_emitted <= 1'b0;
        res_kind    <= '0;
        res_flow    <= '0;
        res_src     <= '0;
        res_dst     <= '0;
        res_fin     <= (cmd.op == tfs_pkg::OP_ALL_DONE) ||
                       ((cmd.op == tfs_pkg::OP_SKIP) && fins_done);
        res_sent    <= (cmd.op == tfs_pkg::OP_RESET_ITEM) ? '0 : sent;
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  // Never overwrite a result that is still waiting
  assert property (@(posedge clk) disable iff (rst)
    cmd.op != tfs_pkg::OP_NOP |-> out_free)
    else $error("result issued while output stage is full");

  // Close a flow only when the scanned entry is unfinished
  assert property (@(posedge clk) disable iff (rst)
    cmd.op == tfs_pkg::OP_CLOSE |-> e_prog < size_eff)
    else $error("close issued on a finished flow");

  // Sent counter moves only by one step up or back to zero
  assert property (@(posedge clk) disable iff (rst)
    sent != $past(sent) |-> sent == $past(sent) + tfs_pkg::SENT_W'(1) || sent == '0)
    else $error("sent counter jumped");

  // A result appears only after the controller issued an operation
  assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(cmd.op) != tfs_pkg::OP_NOP)
    else $error("result valid without an operation");
`endif

endmodule

### rtl/core/tfs_controller.sv
// ============================================================================
// tfs_controller
// Sequencer of the flow scheduler: table clearing sweep, item acceptance,
// modulo iterations, table read/update and the closing scan.
// ============================================================================
module tfs_controller (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  tfs_pkg::ctrl_sts_t sts,
  output tfs_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIVIDE,
    S_READ,
    S_UPDATE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t                          state;
  logic [tfs_pkg::DIV_CNT_W-1:0]   div_cnt;
  tfs_pkg::op_t                    pend_op;

  assign item_ready = (state == S_IDLE);

  // Decode commands for the datapath
  always_comb begin
    cmd = '0;
    cmd.op = tfs_pkg::OP_NOP;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_we = 1'b1;
        cmd.addr_inc = 1'b1;
      end
      S_IDLE:   cmd.load = item_valid;
      S_DIVIDE: cmd.div_step = 1'b1;
      S_READ:   cmd.addr_rem = 1'b1;
      S_UPDATE: begin
        if (sts.out_free) begin
          cmd.op = tfs_pkg::OP_PULL;
        end
      end
      S_SCAN: begin
        priority if (sts.scan_hit) begin
          if (sts.out_free) begin
            cmd.op = tfs_pkg::OP_CLOSE;
          end
        end else if (sts.addr_last) begin
          if (sts.out_free) begin
            cmd.op = tfs_pkg::OP_ALL_DONE;
          end
        end else begin
          cmd.addr_inc = 1'b1;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.op = pend_op;
        end
      end
      default: ;
    endcase
  end

  // Advance the state machine
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      div_cnt <= '0;
      pend_op <= tfs_pkg::OP_NOP;
    end else begin
      unique case (state)
        S_CLEAR: begin
          if (sts.clear_last) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (item_valid) begin
            div_cnt <= '0;
            priority if (sts.command == tfs_pkg::CMD_RESET) begin
              pend_op <= tfs_pkg::OP_RESET_ITEM;
              state   <= S_FINISH;
            end else if (!sts.active || (sts.at_limit && sts.fins_done)) begin
              pend_op <= tfs_pkg::OP_SKIP;
              state   <= S_FINISH;
            end else if (sts.at_limit) begin
              state <= S_SCAN;
            end else begin
              state <= S_DIVIDE;
            end
          end
        end
        S_DIVIDE: begin
          div_cnt <= div_cnt + tfs_pkg::DIV_CNT_W'(1);
          if (div_cnt == tfs_pkg::DIV_CNT_W'(tfs_pkg::DIV_CYCLES - 1)) begin
            state <= S_READ;
          end
        end
        S_READ: state <= S_UPDATE;
        S_UPDATE: begin
          if (sts.out_free) begin
            state <= S_IDLE;
          end
        end
        S_SCAN: begin
          if ((sts.scan_hit || sts.addr_last) && sts.out_free) begin
            state <= S_IDLE;
          end
        end
        S_FINISH: begin
          if (sts.out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
